/* design/cdge_pkg.sv */
// Shared constants for the distance-to-cycle graph engine.
// Used by cycle_distance_graph_engine_core; no dependencies.
`default_nettype none
package cdge_pkg;

    localparam int NODE_W        = 11;
    localparam int HOPS_W        = 10;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 24;
    localparam int MAX_NODES_DEF = 1024;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_CYCLE = 2'd2;

    // Depth-first visit marks.
    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_OPEN = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    localparam logic [HOPS_W-1:0] HOPS_MAX  = 10'd1023;
    localparam logic [NODE_W-1:0] ROOT_NODE = 11'd1;

endpackage
`default_nettype wire

/* design/cdge_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module cdge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/cycle_distance_graph_engine_core.sv */
// Add edge and clear are done in the idle state. A query on a solved graph passes through the
// node read, evaluate and output states before its word is presented, and the next word can be
// accepted once that word is registered, unless output back-pressure holds the output state. The
// first query after a load first clears node memory entries 0 to the edge count, then runs the
// depth-first and tree walks; each edge slot scan reads the edge memory port. Reset (synchronous,
// active low) empties the edge list and marks the graph unsolved; memories are not cleared.
`default_nettype none
module cycle_distance_graph_engine_core #(
    parameter int MAX_NODES = cdge_pkg::MAX_NODES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // node_a [10:0], node_b [21:11], zero fill above
    input  wire logic [cdge_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func [1:0]
    input  wire logic [cdge_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // node_id [10:0], hops [20:11], status [22:21], zero fill above
    output logic      [cdge_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int NW  = cdge_pkg::NODE_W;
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_NODES);
    localparam int PW  = $clog2(2 * MAX_NODES + 1);
    localparam int TW  = $clog2(MAX_NODES + 2);
    localparam int HW  = CW + 1;
    localparam int NRW = HW + 3;
    localparam int SW  = 2 * NW + PW;
    localparam int VW  = CW + NW;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_MSTART, S_SCAN_RD, S_SCAN_EV, S_VCHK, S_FIN_WR, S_POP_LD,
        S_BK, S_BK_LD, S_BK_WR, S_SEEN_RD, S_SEEN_EV, S_HOPU, S_ROOT_RD, S_ROOT_EV,
        S_Q_RD, S_Q_EV, S_OUT
    } t_state;

    function automatic logic [CW-1:0] naddr(input logic [NW-1:0] v);
        logic [VW-1:0] w;
        w = VW'(v);
        return w[CW-1:0];
    endfunction

    function automatic logic [NW-1:0] cnode(input logic [TW-1:0] c);
        logic [TW+NW-1:0] w;
        w = (TW+NW)'(c);
        return w[NW-1:0];
    endfunction

    function automatic logic is_valid(input logic [NW-1:0] v, input logic [CW-1:0] cnt);
        return (v != '0) && (VW'(v) <= VW'(cnt));
    endfunction

    // Neighbor of u through one endpoint slot of an edge, or zero.
    function automatic logic [NW-1:0] slot_nb(input logic [NW-1:0] u, input logic odd,
                                              input logic [2*NW-1:0] ed,
                                              input logic [CW-1:0] cnt);
        logic [NW-1:0] a;
        logic [NW-1:0] b;
        logic [NW-1:0] res;
        a = ed[NW-1:0];
        b = ed[2*NW-1:NW];
        res = '0;
        if (is_valid(a, cnt) && is_valid(b, cnt)) begin
            if (!odd) begin
                res = (a == u) ? b : '0;
            end else begin
                res = (b == u) ? a : '0;
            end
        end
        return res;
    endfunction

    logic [NW-1:0] in_a;
    logic [NW-1:0] in_b;
    assign in_a = s_axis_tdata[NW-1:0];
    assign in_b = s_axis_tdata[2*NW-1:NW];

    t_state r_state, n_state;
    logic r_measure, n_measure;
    logic [CW-1:0] r_ecnt, n_ecnt;
    logic r_solved, n_solved;
    logic r_any, n_any;
    logic [TW-1:0] r_top, n_top;
    logic r_ovalid, n_ovalid;
    logic [NW-1:0] r_a, n_a, r_u, n_u, r_fa, n_fa, r_v, n_v, r_w, n_w;
    logic [PW-1:0] r_pos, n_pos, r_q, n_q;
    logic [CW-1:0] r_k, n_k;
    logic [TW-1:0] r_cnt, n_cnt;
    logic [NRW-1:0] r_vword, n_vword;
    logic [cdge_pkg::HOPS_W-1:0] r_ph, n_ph, r_ohops, n_ohops;
    logic [cdge_pkg::STATUS_W-1:0] r_ps, n_ps, r_ostat, n_ostat;
    logic [NW-1:0] r_onode, n_onode;

    logic edge_we;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    logic [2*NW-1:0] edge_wdata, edge_rdata;
    logic node_we;
    logic [CW-1:0] node_waddr, node_raddr;
    logic [NRW-1:0] node_wdata, node_rdata;
    logic stk_we;
    logic [CW-1:0] stk_waddr, stk_raddr;
    logic [SW-1:0] stk_wdata, stk_rdata;

    cdge_ram #(.WIDTH(2 * NW), .DEPTH(MAX_NODES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    cdge_ram #(.WIDTH(NRW), .DEPTH(MAX_NODES + 1)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    cdge_ram #(.WIDTH(SW), .DEPTH(MAX_NODES + 1)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    always_comb begin
        logic [TW-1:0] top_m1;
        logic [TW-1:0] top_m2;
        logic [PW:0] slot_lim;
        logic [PW-1:0] pos_m1;
        logic [NW-1:0] nb;
        logic [HW-1:0] hop_u;
        logic [HW-1:0] hop_n;
        logic [HW+cdge_pkg::HOPS_W-1:0] hop_wide;
        logic do_pop;
        logic do_push;

        n_state = r_state;   n_measure = r_measure; n_ecnt = r_ecnt;
        n_solved = r_solved; n_any = r_any;         n_top = r_top;
        n_ovalid = r_ovalid; n_a = r_a;   n_u = r_u;  n_fa = r_fa;
        n_v = r_v;   n_w = r_w;   n_pos = r_pos;  n_q = r_q;  n_k = r_k;
        n_cnt = r_cnt;  n_vword = r_vword;  n_ph = r_ph;  n_ps = r_ps;
        n_onode = r_onode;  n_ohops = r_ohops;  n_ostat = r_ostat;

        top_m1   = r_top - TW'(1);
        top_m2   = r_top - TW'(2);
        slot_lim = (PW+1)'({r_ecnt, 1'b0});
        pos_m1   = r_pos - PW'(1);
        nb       = '0;
        hop_u    = node_rdata[NRW-1:3];
        hop_n    = (hop_u == '1) ? hop_u : hop_u + HW'(1);
        hop_wide = (HW+cdge_pkg::HOPS_W)'(node_rdata[NRW-1:3]);
        do_pop   = 1'b0;
        do_push  = 1'b0;

        edge_we    = 1'b0;
        edge_waddr = r_ecnt[EAW-1:0];
        edge_wdata = {in_b, in_a};
        edge_raddr = r_pos[EAW:1];
        node_we    = 1'b0;
        node_waddr = naddr(r_v);
        node_wdata = '0;
        node_raddr = naddr(r_u);
        stk_we     = 1'b0;
        stk_waddr  = top_m1[CW-1:0];
        stk_wdata  = {r_pos, r_fa, r_u};
        stk_raddr  = r_k;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        cdge_pkg::FUNC_CLEAR: begin
                            n_ecnt   = '0;
                            n_solved = 1'b0;
                        end
                        cdge_pkg::FUNC_ADD: begin
                            if (VW'(r_ecnt) < VW'(MAX_NODES)) begin
                                edge_we = 1'b1;
                                n_ecnt  = r_ecnt + CW'(1);
                            end
                            n_solved = 1'b0;
                        end
                        cdge_pkg::FUNC_QUERY: begin
                            n_a = in_a;
                            if (r_solved) begin
                                n_state = S_Q_RD;
                            end else begin
                                n_cnt     = '0;
                                n_any     = 1'b0;
                                n_measure = 1'b0;
                                n_state   = S_CLR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                node_we    = 1'b1;
                node_waddr = r_cnt[CW-1:0];
                node_wdata = '0;
                n_cnt      = r_cnt + TW'(1);
                if (r_cnt == TW'(r_ecnt)) begin
                    if (r_ecnt != '0) begin
                        n_state = S_MSTART;
                    end else begin
                        n_measure = 1'b1;
                        n_cnt     = TW'(1);
                        n_state   = S_ROOT_RD;
                    end
                end
            end
            S_MSTART: begin
                node_we    = 1'b1;
                node_waddr = naddr(cdge_pkg::ROOT_NODE);
                node_wdata = {{(HW+1){1'b0}}, cdge_pkg::MARK_OPEN};
                n_u   = cdge_pkg::ROOT_NODE;
                n_fa  = '0;
                n_pos = '0;
                n_top = TW'(1);
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if ((PW+1)'(r_pos) >= slot_lim) begin
                    if (!r_measure) begin
                        node_raddr = naddr(r_u);
                        n_state    = S_FIN_WR;
                    end else begin
                        do_pop = 1'b1;
                    end
                end else begin
                    edge_raddr = r_pos[EAW:1];
                    n_state    = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                nb    = slot_nb(r_u, r_pos[0], edge_rdata, r_ecnt);
                n_pos = r_pos + PW'(1);
                if (nb == '0 || nb == r_fa) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_v        = nb;
                    node_raddr = naddr(nb);
                    n_state    = S_VCHK;
                end
            end
            S_VCHK: begin
                n_state = S_SCAN_RD;
                if (!r_measure) begin
                    case (node_rdata[1:0])
                        cdge_pkg::MARK_OPEN: begin
                            // Back edge: flag the path from the top down to this node.
                            n_k     = top_m1[CW-1:0];
                            n_state = S_BK;
                        end
                        cdge_pkg::MARK_NEW: begin
                            node_we    = 1'b1;
                            node_waddr = naddr(r_v);
                            node_wdata = {node_rdata[NRW-1:2], cdge_pkg::MARK_OPEN};
                            do_push    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end else if (!node_rdata[2]) begin
                    n_vword = node_rdata;
                    n_q     = '0;
                    n_state = S_SEEN_RD;
                end
            end
            S_FIN_WR: begin
                node_we    = 1'b1;
                node_waddr = naddr(r_u);
                node_wdata = {node_rdata[NRW-1:2], cdge_pkg::MARK_DONE};
                do_pop     = 1'b1;
            end
            S_POP_LD: begin
                n_u     = stk_rdata[NW-1:0];
                n_fa    = stk_rdata[2*NW-1:NW];
                n_pos   = stk_rdata[SW-1:2*NW];
                n_state = S_SCAN_RD;
            end
            S_BK: begin
                if (TW'(r_k) == top_m1) begin
                    n_w        = r_u;
                    node_raddr = naddr(r_u);
                    n_state    = S_BK_WR;
                end else begin
                    stk_raddr = r_k;
                    n_state   = S_BK_LD;
                end
            end
            S_BK_LD: begin
                n_w        = stk_rdata[NW-1:0];
                node_raddr = naddr(stk_rdata[NW-1:0]);
                n_state    = S_BK_WR;
            end
            S_BK_WR: begin
                node_we    = 1'b1;
                node_waddr = naddr(r_w);
                node_wdata = node_rdata | NRW'(4);
                n_any      = 1'b1;
                if (r_w == r_v || r_k == '0) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_k     = r_k - CW'(1);
                    n_state = S_BK;
                end
            end
            S_SEEN_RD: begin
                // Skip a neighbor already reached through an earlier slot.
                if (r_q >= pos_m1) begin
                    node_raddr = naddr(r_u);
                    n_state    = S_HOPU;
                end else begin
                    edge_raddr = r_q[EAW:1];
                    n_state    = S_SEEN_EV;
                end
            end
            S_SEEN_EV: begin
                nb  = slot_nb(r_u, r_q[0], edge_rdata, r_ecnt);
                n_q = r_q + PW'(1);
                n_state = (nb == r_v) ? S_SCAN_RD : S_SEEN_RD;
            end
            S_HOPU: begin
                node_we    = 1'b1;
                node_waddr = naddr(r_v);
                node_wdata = {hop_n, r_vword[2:0]};
                do_push    = 1'b1;
                n_state    = S_SCAN_RD;
            end
            S_ROOT_RD: begin
                if (r_cnt > TW'(r_ecnt)) begin
                    n_solved = 1'b1;
                    n_top    = '0;
                    n_state  = S_Q_RD;
                end else begin
                    node_raddr = r_cnt[CW-1:0];
                    n_state    = S_ROOT_EV;
                end
            end
            S_ROOT_EV: begin
                if (node_rdata[2]) begin
                    node_we    = 1'b1;
                    node_waddr = r_cnt[CW-1:0];
                    node_wdata = {{HW{1'b0}}, node_rdata[2:0]};
                    n_u   = cnode(r_cnt);
                    n_fa  = '0;
                    n_pos = '0;
                    n_top = TW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_cnt   = r_cnt + TW'(1);
                    n_state = S_ROOT_RD;
                end
            end
            S_Q_RD: begin
                node_raddr = naddr(r_a);
                n_state    = S_Q_EV;
            end
            S_Q_EV: begin
                n_ph = '0;
                if (!is_valid(r_a, r_ecnt)) begin
                    n_ps = cdge_pkg::STATUS_RANGE;
                end else if (!r_any) begin
                    n_ps = cdge_pkg::STATUS_NO_CYCLE;
                end else begin
                    n_ps = cdge_pkg::STATUS_OK;
                    if (hop_wide > (HW+cdge_pkg::HOPS_W)'(cdge_pkg::HOPS_MAX)) begin
                        n_ph = cdge_pkg::HOPS_MAX;
                    end else begin
                        n_ph = hop_wide[cdge_pkg::HOPS_W-1:0];
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_onode  = r_a;
                    n_ohops  = r_ph;
                    n_ostat  = r_ps;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_push && !(VW'(r_top) > VW'(MAX_NODES))) begin
            stk_we = 1'b1;
            n_u    = r_v;
            n_fa   = r_u;
            n_pos  = '0;
            n_top  = r_top + TW'(1);
        end

        if (do_pop) begin
            n_top = top_m1;
            if (r_top == TW'(1)) begin
                n_measure = 1'b1;
                n_cnt     = r_measure ? r_cnt + TW'(1) : TW'(1);
                n_state   = S_ROOT_RD;
            end else begin
                stk_raddr = top_m2[CW-1:0];
                n_state   = S_POP_LD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;   r_u <= n_u;   r_fa <= n_fa;  r_v <= n_v;  r_w <= n_w;
        r_pos <= n_pos;  r_q <= n_q;  r_k <= n_k;  r_cnt <= n_cnt;
        r_vword <= n_vword;  r_ph <= n_ph;  r_ps <= n_ps;
        r_onode <= n_onode;  r_ohops <= n_ohops;  r_ostat <= n_ostat;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_measure <= 1'b0;
            r_ecnt    <= '0;
            r_solved  <= 1'b0;
            r_any     <= 1'b0;
            r_top     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_measure <= n_measure;
            r_ecnt    <= n_ecnt;
            r_solved  <= n_solved;
            r_any     <= n_any;
            r_top     <= n_top;
            r_ovalid  <= n_ovalid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ostat, r_ohops, r_onode};

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        VW'(r_top) <= VW'(MAX_NODES + 1))
        else $error("walk stack pointer beyond stack depth");

    a_scan_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EV) |-> (r_top != '0))
        else $error("slot scan with no active frame");

    a_any_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_solved && r_any) |-> (r_ecnt != '0))
        else $error("cycle reported on an empty graph");

    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != cdge_pkg::FUNC_QUERY)
        |=> (r_state == S_IDLE))
        else $error("non-query word left the idle state");

endmodule
`default_nettype wire
